// ===== hw/rtl/aidf_pkg.sv =====
// Shared types and codes for the array insert/delete/find unit.
// Holds the request and result payloads and the controller-datapath interface.
// No dependencies.
`default_nettype none

package aidf_pkg;

  // Request type codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         position;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_position;
    logic [4:0] entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       idx_load_count;
    logic       idx_load_pos;
    logic       idx_clear;
    logic       idx_inc;
    logic       idx_dec;
    logic       mem_rd;
    logic       mem_wr;
    logic       wr_sel_value;
    logic       count_inc;
    logic       count_dec;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_use_idx;
    logic       out_load;
  } dp_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic op_insert;
    logic op_delete;
    logic op_find;
    logic ins_range;
    logic del_range;
    logic full;
    logic pos_eq_count;
    logic del_none;
    logic ins_last;
    logic del_last;
    logic find_last;
    logic count_zero;
    logic match;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aidf_datapath.sv =====
// Datapath of the array insert/delete/find unit: entry memory, count, index and result.
// Depends on aidf_pkg.
`default_nettype none

module aidf_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aidf_pkg::dp_cmd_t      cmd_i,
  input  aidf_pkg::req_t         req_i,
  output aidf_pkg::dp_status_t   status_o,
  output aidf_pkg::rsp_t         rsp_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > 5) ? CntW : 5) + 2;

  logic [31:0]     mem [CAPACITY];

  aidf_pkg::req_t  req_q;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] raddr;
  logic [31:0]     rdata_q;
  logic [31:0]     wdata;
  logic [1:0]      res_status_q;
  logic [IdxW-1:0] res_found_q;
  aidf_pkg::rsp_t  rsp_q;

  logic [CmpW-1:0] pos_x, cnt_x, idx_x, cap_x;
  logic            op_insert, op_delete;

  assign op_insert = (req_q.req_type == aidf_pkg::OP_INSERT);
  assign op_delete = (req_q.req_type == aidf_pkg::OP_DELETE);

  assign pos_x = CmpW'(req_q.position);
  assign cnt_x = CmpW'(count_q);
  assign idx_x = CmpW'(idx_q);
  assign cap_x = CmpW'(CAPACITY);

  always_comb begin
    status_o.op_insert    = op_insert;
    status_o.op_delete    = op_delete;
    status_o.op_find      = (req_q.req_type == aidf_pkg::OP_FIND);
    status_o.ins_range    = (pos_x > cnt_x);
    status_o.del_range    = (pos_x >= cnt_x);
    status_o.full         = (cnt_x >= cap_x);
    status_o.pos_eq_count = (pos_x == cnt_x);
    status_o.del_none     = ((pos_x + CmpW'(1)) >= cnt_x);
    status_o.ins_last     = (idx_x == (pos_x + CmpW'(1)));
    status_o.del_last     = ((idx_x + CmpW'(2)) >= cnt_x);
    status_o.find_last    = ((idx_x + CmpW'(1)) >= cnt_x);
    status_o.count_zero   = (count_q == '0);
    status_o.match        = (rdata_q == req_q.data_value);
  end

  // Inserts shift from the entry below, deletes from the entry above.
  always_comb begin
    if (op_insert) begin
      raddr = idx_q - IdxW'(1);
    end else if (op_delete) begin
      raddr = idx_q + IdxW'(1);
    end else begin
      raddr = idx_q;
    end
  end

  assign wdata = cmd_i.wr_sel_value ? req_q.data_value : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[idx_q] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_load_count) begin
      idx_d = IdxW'(count_q);
    end else if (cmd_i.idx_load_pos) begin
      idx_d = IdxW'(req_q.position);
    end else if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IdxW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.count_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.count_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_use_idx ? idx_q : '0;
    end
    if (cmd_i.out_load) begin
      rsp_q.status         <= res_status_q;
      rsp_q.found_position <= 4'(res_found_q);
      rsp_q.entry_count    <= 5'(count_q);
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aidf_controller.sv =====
// Controller state machine of the array insert/delete/find unit.
// Sequences memory shifts and scans and owns both handshakes. Depends on aidf_pkg.
`default_nettype none

module aidf_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  aidf_pkg::dp_status_t status_i,
  output aidf_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_SHIFT_RD = 8'b0000_0100,
    S_SHIFT_WR = 8'b0000_1000,
    S_LOAD     = 8'b0001_0000,
    S_FIND_RD  = 8'b0010_0000,
    S_FIND_CMP = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.op_insert) begin
          if (status_i.ins_range) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = aidf_pkg::ST_RANGE;
            state_d          = S_DONE;
          end else if (status_i.full) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = aidf_pkg::ST_FULL;
            state_d          = S_DONE;
          end else begin
            cmd_o.idx_load_count = 1'b1;
            state_d = status_i.pos_eq_count ? S_LOAD : S_SHIFT_RD;
          end
        end else if (status_i.op_delete) begin
          if (status_i.del_range) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = aidf_pkg::ST_RANGE;
            state_d          = S_DONE;
          end else if (status_i.del_none) begin
            cmd_o.count_dec  = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = aidf_pkg::ST_OK;
            state_d          = S_DONE;
          end else begin
            cmd_o.idx_load_pos = 1'b1;
            state_d            = S_SHIFT_RD;
          end
        end else if (status_i.op_find) begin
          cmd_o.idx_clear = 1'b1;
          if (status_i.count_zero) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = aidf_pkg::ST_MISS;
            state_d          = S_DONE;
          end else begin
            state_d = S_FIND_RD;
          end
        end else begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = aidf_pkg::ST_OK;
          state_d          = S_DONE;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.mem_wr = 1'b1;
        if (status_i.op_insert) begin
          cmd_o.idx_dec = 1'b1;
          state_d = status_i.ins_last ? S_LOAD : S_SHIFT_RD;
        end else if (status_i.del_last) begin
          cmd_o.count_dec  = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = aidf_pkg::ST_OK;
          state_d          = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SHIFT_RD;
        end
      end
      S_LOAD: begin
        cmd_o.mem_wr       = 1'b1;
        cmd_o.wr_sel_value = 1'b1;
        cmd_o.count_inc    = 1'b1;
        cmd_o.res_set      = 1'b1;
        cmd_o.res_status   = aidf_pkg::ST_OK;
        state_d            = S_DONE;
      end
      S_FIND_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (status_i.match) begin
          cmd_o.res_set     = 1'b1;
          cmd_o.res_status  = aidf_pkg::ST_OK;
          cmd_o.res_use_idx = 1'b1;
          state_d           = S_DONE;
        end else if (status_i.find_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = aidf_pkg::ST_MISS;
          state_d          = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_FIND_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/array_insert_delete_find_unit.sv =====
// Top level of the array insert/delete/find unit.
// Instantiates aidf_controller and aidf_datapath; depends on aidf_pkg.
//
// This unit keeps a packed list of up to CAPACITY signed 32-bit entries in a
// single-port memory, with a running entry count. Each request is an insert
// (value placed at a position from 0 to the count, later entries move up), a
// delete (entry at a position below the count removed, later entries move
// down) or a find (lowest index whose entry equals the value). Every request
// gives exactly one result carrying a status, the found index for a hit and
// the entry count after the request. Requests are handled one at a time. The
// cost is set by the entry memory, which moves each entry with one read and
// then one write: an insert or delete shifts the entries after its position,
// a find reads entries from index 0 until it hits or passes the count, and
// rejected or unused request types skip the memory. A finished result sits
// in an output register, so the next request may be accepted while the
// previous result is still stalled; the new request then holds in its done
// state, and keeps the input stalled, until that register has been taken.
// Entries are not cleared at reset; only entries below the count are ever
// read.
`default_nettype none

module array_insert_delete_find_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  aidf_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output aidf_pkg::rsp_t  out_rsp_o
);

  // Command and status groups between the sequencer and the datapath.
  aidf_pkg::dp_cmd_t    dp_cmd;
  aidf_pkg::dp_status_t dp_status;

  // The controller accepts a request only when idle, walks the shift or
  // scan one entry at a time and loads the output register when it is free.
  aidf_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // The datapath holds the entries, the count, the walking index and the
  // result registers.
  aidf_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .req_i    (in_req_i),
    .status_o (dp_status),
    .rsp_o    (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/aidf_checker.sv =====
// Port-level checks for the array insert/delete/find unit.
// Bound to array_insert_delete_find_unit; depends on aidf_pkg.
`default_nettype none

module aidf_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input aidf_pkg::rsp_t out_rsp_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Requests are taken one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in progress");

  // A request that does not succeed reports a zero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != aidf_pkg::ST_OK)
      |-> (out_rsp_o.found_position == 4'd0))
    else $error("failing request reports an index");

  // A full report comes only with the count at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == aidf_pkg::ST_FULL)
      |-> (out_rsp_o.entry_count == 5'(CAPACITY)))
    else $error("full status below capacity");

endmodule

bind array_insert_delete_find_unit aidf_checker #(
  .CAPACITY (CAPACITY)
) u_aidf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
